>>> hw/rtl/lmeg_pkg.sv
// ============================================================================
// lmeg_pkg
// Shared types and constants of the LED mood effect generator: register
// indexes, mode codes, sine table geometry and fixed-point increments.
// ============================================================================
`default_nettype none

package lmeg_pkg;

    // Sine table geometry (Q1.15 samples over one turn)
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH);
    localparam int SINE_QTR         = SINE_TABLE_DEPTH / 4;

    // Flicker step counter
    localparam int                 STEP_W             = 14;
    localparam logic [STEP_W-1:0]  FLICKER_WRAP_STEPS = STEP_W'(12566);

    // Per-step phase increments, Q0.32 turns
    localparam logic [31:0] INC_W1 = 32'd34178264;
    localparam logic [31:0] INC_W2 = 32'd78610007;
    localparam logic [31:0] INC_W3 = 32'd194816104;

    // Thinking pulse increment per ms, Q0.48 turns
    localparam logic [39:0] INC_PULSE = 40'd358385071202;

    // Shared multiplier operand widths
    localparam int MUL_A_W = 24;
    localparam int MUL_B_W = 40;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Configuration register indexes
    localparam int             CFG_IDX_W      = 3;
    localparam logic [CFG_IDX_W-1:0] REG_LED_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_RED   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_GREEN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_BLUE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL   = 3'd4;

    // LED modes
    typedef enum logic [1:0] {
        MODE_STANDBY = 2'd0,
        MODE_LISTEN  = 2'd1,
        MODE_THINK   = 2'd2,
        MODE_SPEAK   = 2'd3
    } led_mode_t;

endpackage : lmeg_pkg

`default_nettype wire

>>> hw/rtl/lmeg_mul.sv
// ============================================================================
// lmeg_mul
// Shared unsigned multiplier with a registered product. Used for phase
// accumulation, reciprocal division and channel scaling.
// ============================================================================
`default_nettype none

module lmeg_mul
    import lmeg_pkg::*;
(
    input  wire logic               clk,
    input  wire logic [MUL_A_W-1:0] a,
    input  wire logic [MUL_B_W-1:0] b,
    output logic      [MUL_P_W-1:0] prod
);

    logic [MUL_P_W-1:0] prod_reg;

    // Register the product
    always_ff @(posedge clk)
    begin
        prod_reg <= MUL_P_W'(a) * MUL_P_W'(b);
    end

    assign prod = prod_reg;

endmodule : lmeg_mul

`default_nettype wire

>>> hw/rtl/lmeg_sine.sv
// ============================================================================
// lmeg_sine
// Sine lookup by table index over one turn. A quarter-wave table is built at
// elaboration; quadrant folding and sign give the full wave. Output is
// registered, Q1.15.
// ============================================================================
`default_nettype none

module lmeg_sine
    import lmeg_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic [SINE_IDX_W-1:0] idx,
    output logic signed [15:0]         sample
);

    localparam int          QTR_W      = SINE_IDX_W - 2;
    localparam logic [63:0] ONE_Q30    = 64'h4000_0000;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] U_STEP     = ONE_Q30 / SINE_QTR;

    typedef logic [SINE_QTR-1:0][15:0] qsin_tab_t;

    // Quarter wave: odd Taylor polynomial to x^11 in Q30, rounded to Q1.15
    function automatic qsin_tab_t build_qsin();
        qsin_tab_t   tab;
        logic [63:0] u;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] p;
        logic [63:0] s;
        logic [63:0] mag;
        for (int j = 0; j < SINE_QTR; j++)
        begin
            u   = 64'(j) * U_STEP;
            x   = (u * HALF_PI_Q30) >> 30;
            x2  = (x * x) >> 30;
            p   = ONE_Q30 - x2 / 110;
            p   = ONE_Q30 - ((x2 * p) >> 30) / 72;
            p   = ONE_Q30 - ((x2 * p) >> 30) / 42;
            p   = ONE_Q30 - ((x2 * p) >> 30) / 20;
            p   = ONE_Q30 - ((x2 * p) >> 30) / 6;
            s   = (x * p) >> 30;
            mag = (s + 64'd16384) >> 15;
            if (mag > 64'd32767)
            begin
                mag = 64'd32767;
            end
            tab[j] = mag[15:0];
        end
        return tab;
    endfunction

    localparam qsin_tab_t QSIN = build_qsin();

    logic [1:0]       quad;
    logic [QTR_W-1:0] pos;
    logic [QTR_W:0]   fold;
    logic [15:0]      mag;
    logic signed [15:0] sample_reg;
    logic signed [15:0] sample_next;

    // Fold the index into the first quadrant
    always_comb
    begin
        quad = idx[SINE_IDX_W-1 -: 2];
        pos  = idx[QTR_W-1:0];
        fold = quad[0] ? (QTR_W+1)'(SINE_QTR) - {1'b0, pos} : {1'b0, pos};
        if (fold[QTR_W])
        begin
            mag = 16'd32767;
        end
        else
        begin
            mag = QSIN[fold[QTR_W-1:0]];
        end
        sample_next = quad[1] ? -$signed(mag) : $signed(mag);
    end

    // Hold the sample
    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
    end

    assign sample = sample_reg;

endmodule : lmeg_sine

`default_nettype wire

>>> hw/rtl/led_mood_effect_generator.sv
// ============================================================================
// led_mood_effect_generator
// Rate-limited RGB mood color generator with standby flicker and thinking
// pulse, built on one shared multiplier under a sequencer.
// ============================================================================
// Each beat on the input carries a millisecond timestamp. A beat that comes
// sooner than update_interval ms after the last emitted frame (wrapping
// difference) is dropped in the check state and gives no output. Otherwise one
// color beat follows. Fixed green (listening) and fixed blue (speaking) go
// straight from the check to the done state; the blue pulse (thinking) and
// the base color scaled by a flicker factor (standby) come from the
// sequencer passing every product through the single registered
// multiplier: two pulse phase products with one sine lookup in thinking,
// three phase products with sine lookups in standby, two for the divide by
// reciprocal and, in standby, three for channel scaling. A finished color
// moves into the output register and waits there without blocking the next
// timestamp; only when that register still holds an untaken beat does the
// sequencer hold. Registers are to be written by the user only while the
// block is idle; the block itself does not enforce this.
// ============================================================================
`default_nettype none

module led_mood_effect_generator
    import lmeg_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // timestamp channel
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [31:0]          time_ms,
    // color channel
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [7:0]                red_out,
    output logic [7:0]                green_out,
    output logic [7:0]                blue_out,
    // configuration
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]           cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_STEP,
        ST_W_MUL,
        ST_W_TURN,
        ST_W_ACC,
        ST_F_NUM,
        ST_P_LO,
        ST_P_HI,
        ST_P_TURN,
        ST_P_SAMP,
        ST_DIV_MUL,
        ST_DIV_Q,
        ST_DIV_CORR,
        ST_CH_R,
        ST_CH_G,
        ST_CH_B,
        ST_CH_END,
        ST_DONE
    } state_t;

    localparam int          Q_W      = 17;
    localparam logic [39:0] RECIP_35 = 40'((64'd1 << 40) / 64'd35);
    localparam logic [39:0] RECIP_PL = 40'((64'd1 << 40) / 64'd65534);
    localparam logic [23:0] DIV_35   = 24'd35;
    localparam logic [23:0] DIV_PL   = 24'd65534;
    localparam logic [23:0] FACTOR_BIAS = 24'd1376256;
    localparam logic [31:0] RND_32   = 32'd1 << (31 - SINE_IDX_W);
    localparam logic [47:0] RND_48   = 48'd1 << (47 - SINE_IDX_W);
    localparam logic [15:0] FACTOR_MAX = 16'hFFFF;

    state_t state_reg;

    // configuration registers
    led_mode_t  mode_reg;
    logic [7:0] base_r_reg;
    logic [7:0] base_g_reg;
    logic [7:0] base_b_reg;
    logic [7:0] interval_reg;

    // item state
    logic [31:0]        now_reg;
    logic [31:0]        last_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [1:0]         wave_reg;
    logic signed [18:0] sum_reg;
    logic [47:0]        turn_reg;
    logic [23:0]        num_reg;
    logic               by35_reg;
    logic [Q_W-1:0]     q_reg;
    logic [15:0]        factor_reg;
    logic [7:0]         res_r_reg;
    logic [7:0]         res_g_reg;
    logic [7:0]         res_b_reg;

    // output register
    logic       out_valid_reg;
    logic [7:0] out_r_reg;
    logic [7:0] out_g_reg;
    logic [7:0] out_b_reg;

    // shared units
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] prod;
    logic [SINE_IDX_W-1:0] sine_idx;
    logic signed [15:0]    sample;

    // combinational helpers
    logic [31:0]        delta;
    logic [STEP_W:0]    step_inc;
    logic [STEP_W-1:0]  step_next;
    logic [31:0]        turn32;
    logic [47:0]        turn48;
    logic signed [18:0] wave_term;
    logic signed [23:0] factor_num;
    logic [16:0]        pulse_v;
    logic [23:0]        pulse_n;
    logic [23:0]        div_d;
    logic [23:0]        div_rem;
    logic [Q_W-1:0]     q_fix;
    logic [31:0]        wave_inc;
    logic               load_out;

    lmeg_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    lmeg_sine u_sine (
        .clk    (clk),
        .idx    (sine_idx),
        .sample (sample)
    );

    // Datapath helpers
    always_comb
    begin
        delta     = now_reg - last_reg;
        step_inc  = {1'b0, step_reg} + (STEP_W+1)'(1);
        step_next = (step_inc > {1'b0, FLICKER_WRAP_STEPS}) ? '0 : step_inc[STEP_W-1:0];

        unique case (wave_reg)
            2'd0:    wave_inc = INC_W1;
            2'd1:    wave_inc = INC_W2;
            default: wave_inc = INC_W3;
        endcase

        turn32 = prod[31:0] + RND_32;
        turn48 = turn_reg + {prod[31:0], 16'b0};

        unique case (wave_reg)
            2'd0:    wave_term = 19'(sample) <<< 2;
            2'd1:    wave_term = 19'(sample) <<< 1;
            default: wave_term = 19'(sample);
        endcase

        factor_num = $signed(FACTOR_BIAS) + (24'(sum_reg) <<< 2);
        pulse_v    = 17'(sample) + 17'd32767;
        pulse_n    = {pulse_v[15:0], 8'b0} - {8'b0, pulse_v[15:0]};

        div_d   = by35_reg ? DIV_35 : DIV_PL;
        div_rem = num_reg - prod[23:0];
        q_fix   = (div_rem >= div_d) ? q_reg + Q_W'(1) : q_reg;

        if (state_reg == ST_P_TURN)
        begin
            sine_idx = turn48[47 -: SINE_IDX_W];
        end
        else
        begin
            sine_idx = turn32[31 -: SINE_IDX_W];
        end
    end

    // Move a finished color into the output register once it is free
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // Drive the shared multiplier from the sequencer
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_W_MUL:
            begin
                mul_a = MUL_A_W'(step_reg);
                mul_b = MUL_B_W'(wave_inc);
            end
            ST_P_LO:
            begin
                mul_a = MUL_A_W'(now_reg[15:0]);
                mul_b = INC_PULSE;
            end
            ST_P_HI:
            begin
                mul_a = MUL_A_W'(now_reg[31:16]);
                mul_b = MUL_B_W'(INC_PULSE[31:0]);
            end
            ST_DIV_MUL:
            begin
                mul_a = num_reg;
                mul_b = by35_reg ? RECIP_35 : RECIP_PL;
            end
            ST_DIV_Q:
            begin
                mul_a = MUL_A_W'(prod[40 +: Q_W]);
                mul_b = MUL_B_W'(div_d);
            end
            ST_CH_R:
            begin
                mul_a = MUL_A_W'(base_r_reg);
                mul_b = MUL_B_W'(factor_reg);
            end
            ST_CH_G:
            begin
                mul_a = MUL_A_W'(base_g_reg);
                mul_b = MUL_B_W'(factor_reg);
            end
            ST_CH_B:
            begin
                mul_a = MUL_A_W'(base_b_reg);
                mul_b = MUL_B_W'(factor_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_STANDBY;
            base_r_reg   <= 8'd255;
            base_g_reg   <= 8'd60;
            base_b_reg   <= 8'd0;
            interval_reg <= 8'd20;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_LED_MODE:   mode_reg     <= led_mode_t'(cfg_data[1:0]);
                REG_BASE_RED:   base_r_reg   <= cfg_data;
                REG_BASE_GREEN: base_g_reg   <= cfg_data;
                REG_BASE_BLUE:  base_b_reg   <= cfg_data;
                REG_INTERVAL:   interval_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Sequencer, item state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            last_reg      <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            wave_reg      <= '0;
        end
        else
        begin
            // load a finished color, or drop the output beat once taken
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        now_reg   <= time_ms;
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    if (delta < {24'b0, interval_reg})
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        last_reg  <= now_reg;
                        res_r_reg <= 8'd0;
                        res_g_reg <= (mode_reg == MODE_LISTEN) ? 8'd255 : 8'd0;
                        res_b_reg <= (mode_reg == MODE_SPEAK) ? 8'd255 : 8'd0;
                        unique case (mode_reg)
                            MODE_STANDBY: state_reg <= ST_STEP;
                            MODE_LISTEN:  state_reg <= ST_DONE;
                            MODE_THINK:   state_reg <= ST_P_LO;
                            MODE_SPEAK:   state_reg <= ST_DONE;
                        endcase
                    end
                end
                ST_STEP:
                begin
                    step_reg  <= step_next;
                    sum_reg   <= '0;
                    wave_reg  <= '0;
                    state_reg <= ST_W_MUL;
                end
                ST_W_MUL:  state_reg <= ST_W_TURN;
                ST_W_TURN: state_reg <= ST_W_ACC;
                ST_W_ACC:
                begin
                    sum_reg <= sum_reg + wave_term;
                    if (wave_reg == 2'd2)
                    begin
                        state_reg <= ST_F_NUM;
                    end
                    else
                    begin
                        wave_reg  <= wave_reg + 2'd1;
                        state_reg <= ST_W_MUL;
                    end
                end
                ST_F_NUM:
                begin
                    num_reg   <= 24'(unsigned'(factor_num));
                    by35_reg  <= 1'b1;
                    state_reg <= ST_DIV_MUL;
                end
                ST_P_LO:   state_reg <= ST_P_HI;
                ST_P_HI:
                begin
                    turn_reg  <= prod[47:0] + RND_48;
                    state_reg <= ST_P_TURN;
                end
                ST_P_TURN: state_reg <= ST_P_SAMP;
                ST_P_SAMP:
                begin
                    num_reg   <= pulse_n;
                    by35_reg  <= 1'b0;
                    state_reg <= ST_DIV_MUL;
                end
                ST_DIV_MUL: state_reg <= ST_DIV_Q;
                ST_DIV_Q:
                begin
                    q_reg     <= prod[40 +: Q_W];
                    state_reg <= ST_DIV_CORR;
                end
                ST_DIV_CORR:
                begin
                    if (by35_reg)
                    begin
                        factor_reg <= q_fix[16] ? FACTOR_MAX : q_fix[15:0];
                        state_reg  <= ST_CH_R;
                    end
                    else
                    begin
                        res_b_reg <= q_fix[7:0];
                        state_reg <= ST_DONE;
                    end
                end
                ST_CH_R: state_reg <= ST_CH_G;
                ST_CH_G:
                begin
                    res_r_reg <= prod[23:16];
                    state_reg <= ST_CH_B;
                end
                ST_CH_B:
                begin
                    res_g_reg <= prod[23:16];
                    state_reg <= ST_CH_END;
                end
                ST_CH_END:
                begin
                    res_b_reg <= prod[23:16];
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    // wait for the output register to free up
                    if (load_out)
                    begin
                        out_r_reg <= res_r_reg;
                        out_g_reg <= res_g_reg;
                        out_b_reg <= res_b_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign red_out   = out_r_reg;
    assign green_out = out_g_reg;
    assign blue_out  = out_b_reg;

    // An accepted timestamp is checked against the interval next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_CHECK))
        else $error("accepted timestamp not checked");

    // A dropped timestamp leaves the frame time alone
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK && delta < {24'b0, interval_reg}) |=> $stable(last_reg))
        else $error("dropped timestamp moved frame time");

    // Non-standby frames leave the flicker step alone
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK && mode_reg != MODE_STANDBY) |=> $stable(step_reg))
        else $error("flicker step moved outside standby");

    // The flicker step never passes the wrap point
    assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= FLICKER_WRAP_STEPS)
        else $error("flicker step beyond wrap");

    // The flicker factor stays inside its known range when scaling starts
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CH_R) |-> (factor_reg >= 16'd13108))
        else $error("flicker factor out of range");

endmodule : led_mood_effect_generator

`default_nettype wire

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LED mood effect generator.
// ----------------------------------------------------------------------------
// Timestamps are sent on the input channel with random gaps while the color
// channel stalls at random. A scoreboard keeps its own copy of the registers,
// the frame timer, the flicker step and the sine table. For every accepted
// timestamp it applies the interval check and works out the color that is
// due, and it compares each color beat against the oldest expected frame.
// A directed opening covers the interval edges, timer wrap, every mode, a
// zero interval and the unused register indexes. Random phases with new
// settings follow, then a standby run with a zero interval in which every
// timestamp advances the flicker.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import lmeg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 7;
    localparam int IDLE_PCT      = 28;
    localparam int SETTLE_CYCLES = 64;
    localparam int STALL_LIMIT   = 2000;
    localparam int RAND_PHASES   = 5;
    localparam int PHASE_ITEMS   = 100;
    localparam int RUN_ITEMS     = 80;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // Expected color frames, worked out from a private copy of the block state
    class color_scoreboard;
        localparam logic [63:0] ONE_Q30     = 64'h4000_0000;
        localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

        led_mode_t          mode;
        logic [7:0]         base_r;
        logic [7:0]         base_g;
        logic [7:0]         base_b;
        logic [7:0]         span;
        logic [31:0]        last_frame;
        logic [STEP_W-1:0]  step;
        logic [15:0]        sine_rom [SINE_TABLE_DEPTH];
        rgb_t               colors_due [$];
        int                 errors;

        function new();
            logic [63:0] t, u, x, x2, p, s, mag;
            logic [1:0]  quad;
            // Build the Q1.15 sine table from a first-quadrant polynomial
            for (int k = 0; k < SINE_TABLE_DEPTH; k++)
            begin
                t    = (64'(k) << 32) / SINE_TABLE_DEPTH;
                quad = t[31:30];
                u    = t & (ONE_Q30 - 1);
                if (quad[0])
                    u = ONE_Q30 - u;
                x   = (u * HALF_PI_Q30) >> 30;
                x2  = (x * x) >> 30;
                p   = ONE_Q30 - x2 / 110;
                p   = ONE_Q30 - ((x2 * p) >> 30) / 72;
                p   = ONE_Q30 - ((x2 * p) >> 30) / 42;
                p   = ONE_Q30 - ((x2 * p) >> 30) / 20;
                p   = ONE_Q30 - ((x2 * p) >> 30) / 6;
                s   = (x * p) >> 30;
                mag = (s + 16384) >> 15;
                if (mag > 32767)
                    mag = 32767;
                sine_rom[k] = quad[1] ? 16'(64'h1_0000 - mag) : mag[15:0];
            end
            mode       = MODE_STANDBY;
            base_r     = 8'd255;
            base_g     = 8'd60;
            base_b     = 8'd0;
            span       = 8'd20;
            last_frame = '0;
            step       = '0;
            errors     = 0;
        endfunction

        function int pending();
            return colors_due.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
            case (idx)
                REG_LED_MODE:   mode   = led_mode_t'(data[1:0]);
                REG_BASE_RED:   base_r = data;
                REG_BASE_GREEN: base_g = data;
                REG_BASE_BLUE:  base_b = data;
                REG_INTERVAL:   span   = data;
                default: ;
            endcase
        endfunction

        // Round a turn fraction to a table index and return the signed sample
        function int sine_at(logic [63:0] turn, int frac_bits);
            logic [63:0] idx;
            idx = (turn * SINE_TABLE_DEPTH + (64'd1 << (frac_bits - 1))) >> frac_bits;
            return int'($signed(sine_rom[idx % SINE_TABLE_DEPTH]));
        endfunction

        // Apply the interval check and queue the color of an emitted frame
        function void note_time(logic [31:0] now);
            rgb_t            c;
            int              w1, w2, w3, w, factor;
            logic [STEP_W:0] nxt;
            logic [63:0]     turn;
            if (32'(now - last_frame) < 32'(span))
                return;
            last_frame = now;
            c = '0;
            case (mode)
                MODE_STANDBY:
                begin
                    nxt = {1'b0, step} + 1'b1;
                    if (nxt > (STEP_W + 1)'(FLICKER_WRAP_STEPS))
                        nxt = '0;
                    step   = nxt[STEP_W-1:0];
                    w1     = sine_at((64'(step) * INC_W1) & 64'hFFFF_FFFF, 32);
                    w2     = sine_at((64'(step) * INC_W2) & 64'hFFFF_FFFF, 32);
                    w3     = sine_at((64'(step) * INC_W3) & 64'hFFFF_FFFF, 32);
                    factor = (1376256 + 4 * (4 * w1 + 2 * w2 + w3)) / 35;
                    if (factor > 65535)
                        factor = 65535;
                    c.red   = 8'((int'(base_r) * factor) >> 16);
                    c.green = 8'((int'(base_g) * factor) >> 16);
                    c.blue  = 8'((int'(base_b) * factor) >> 16);
                end
                MODE_LISTEN: c.green = 8'hFF;
                MODE_THINK:
                begin
                    turn   = (64'(now) * 64'(INC_PULSE)) & 64'hFFFF_FFFF_FFFF;
                    w      = sine_at(turn, 48);
                    c.blue = 8'((255 * (w + 32767)) / 65534);
                end
                default: c.blue = 8'hFF;
            endcase
            colors_due.push_back(c);
        endfunction

        function void check_color(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
            rgb_t want;
            if (colors_due.size() == 0)
            begin
                $error("color beat with no frame due: red %0d green %0d blue %0d",
                       red, green, blue);
                errors++;
                return;
            end
            want = colors_due.pop_front();
            if (red !== want.red)
            begin
                $error("red_out: expected %0d, actual %0d", want.red, red);
                errors++;
            end
            if (green !== want.green)
            begin
                $error("green_out: expected %0d, actual %0d", want.green, green);
                errors++;
            end
            if (blue !== want.blue)
            begin
                $error("blue_out: expected %0d, actual %0d", want.blue, blue);
                errors++;
            end
        endfunction
    endclass

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic [31:0]          time_ms   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [7:0]           red_out;
    logic [7:0]           green_out;
    logic [7:0]           blue_out;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_data  = '0;

    color_scoreboard sb;
    int              idle_pct    = IDLE_PCT;
    int              stall_count = 0;

    led_mood_effect_generator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .time_ms   (time_ms),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Check each color beat, then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_color(red_out, green_out, blue_out);
        out_ready <= ($urandom_range(0, 99) >= idle_pct);
    end

    // Watchdog: end the run after too long without any beat or write
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Present one timestamp, idling first at random, and hold until accepted
    task automatic send_time(input logic [31:0] stamp);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
        end
        in_valid <= 1'b1;
        time_ms  <= stamp;
        do @(posedge clk); while (!in_ready);
        sb.note_time(stamp);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    // Drain, let a dropped timestamp finish, then write every register index
    task automatic apply_setting(input led_mode_t m, input logic [7:0] r,
                                 input logic [7:0] g, input logic [7:0] b,
                                 input logic [7:0] span);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(REG_LED_MODE, {6'($urandom()), m});
        write_reg(REG_BASE_RED, r);
        write_reg(REG_BASE_GREEN, g);
        write_reg(REG_BASE_BLUE, b);
        write_reg(REG_INTERVAL, span);
        for (int i = REG_INTERVAL + 1; i < 2 ** CFG_IDX_W; i++)
            write_reg(CFG_IDX_W'(i), 8'($urandom()));
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 6))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom());
        endcase
    endfunction

    function automatic logic [7:0] pick_span();
        case ($urandom_range(0, 9))
            0, 1:    return 8'd0;
            2:       return 8'd255;
            3:       return 8'd1;
            default: return 8'($urandom_range(1, 40));
        endcase
    endfunction

    // Step time mostly around the interval, sometimes far or anywhere
    function automatic logic [31:0] next_stamp(logic [31:0] cur, logic [7:0] span);
        case ($urandom_range(0, 9))
            0:       return $urandom();
            1:       return cur + $urandom_range(0, 2);
            2:       return cur + $urandom();
            default: return cur + $urandom_range(0, 2 * span + 2);
        endcase
    endfunction

    initial
    begin
        logic [31:0] stamp;
        logic [7:0]  span;
        sb    = new();
        stamp = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: interval edges and timer wrap in standby
        send_time(32'd0);
        send_time(32'd19);
        send_time(32'd20);
        send_time(32'd39);
        send_time(32'd40);
        send_time(32'hFFFF_FFFF);
        send_time(32'd0);
        send_time(32'd19);

        // Listening with the longest interval
        apply_setting(MODE_LISTEN, 8'd255, 8'd255, 8'd255, 8'd255);
        send_time(32'd273);
        send_time(32'd274);

        // Thinking with zero interval: repeated stamps all emit
        apply_setting(MODE_THINK, 8'd0, 8'd0, 8'd0, 8'd0);
        send_time(32'd0);
        send_time(32'd0);
        send_time(32'hFFFF_FFFF);
        send_time(32'h8000_0000);
        send_time($urandom());

        // Speaking with the shortest non-zero interval
        apply_setting(MODE_SPEAK, 8'd0, 8'd0, 8'd0, 8'd1);
        send_time(32'd5);
        send_time(32'd5);
        send_time(32'd6);

        // Standby at full and at zero base color
        apply_setting(MODE_STANDBY, 8'd255, 8'd255, 8'd255, 8'd1);
        send_time(32'd100);
        send_time(32'd101);
        send_time(32'd102);
        apply_setting(MODE_STANDBY, 8'd0, 8'd0, 8'd0, 8'd1);
        send_time(32'd103);
        send_time(32'd104);

        // Random settings, one phase without any idling
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            span = pick_span();
            apply_setting(led_mode_t'($urandom_range(0, 3)), pick_level(), pick_level(),
                          pick_level(), span);
            idle_pct = (ph == 2) ? 0 : IDLE_PCT;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                stamp = next_stamp(stamp, span);
                send_time(stamp);
            end
        end
        idle_pct = IDLE_PCT;

        // Standby run where every stamp advances the flicker
        apply_setting(MODE_STANDBY, pick_level(), pick_level(), pick_level(), 8'd0);
        repeat (RUN_ITEMS)
            send_time($urandom());

        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
